[src/baro_temp_pressure_compensation_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the barometric compensation block
// Each macro compiles away when ASSERT_OFF is defined
// ----------------------------------------------------------------------------
`ifndef BARO_TEMP_PRESSURE_COMPENSATION_ASSERT_SVH
`define BARO_TEMP_PRESSURE_COMPENSATION_ASSERT_SVH
`ifndef ASSERT_OFF
`define ASSERT_PROP(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk_s, rst_s, expr) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) !(expr)) else $error("assertion failed");
`else
`define ASSERT_PROP(lbl, clk_s, rst_s, prop)
`define ASSERT_NEVER(lbl, clk_s, rst_s, expr)
`endif
`endif

[src/btpc_pkg.sv]
// ----------------------------------------------------------------------------
// btpc_pkg
// Shared constants, register indexes and arithmetic helpers
// ----------------------------------------------------------------------------
package btpc_pkg;

  localparam int BTPC_DIV_STEP = 2;

  localparam logic [31:0] RST_AC1_AC2 = 32'd26804152;
  localparam logic [31:0] RST_AC3_AC4 = 32'd3352395749;
  localparam logic [31:0] RST_AC5_AC6 = 32'd2146785905;
  localparam logic [31:0] RST_B1_B2   = 32'd405667844;
  localparam logic [31:0] RST_MC_MD   = 32'd3724086068;
  localparam logic [1:0]  RST_OSS     = 2'd2;

  localparam logic [31:0] C_B6_OFFSET = 32'd4000;
  localparam logic [31:0] C_B4_BIAS   = 32'd32768;
  localparam logic [31:0] C_B7_SCALE  = 32'd50000;
  localparam logic [31:0] C_P_K1      = 32'd3038;
  localparam logic [31:0] C_P_K2      = 32'hFFFF_E343;
  localparam logic [31:0] C_P_K3      = 32'd3791;
  localparam logic [31:0] C_SIGN_BIT  = 32'h8000_0000;

  localparam logic signed [31:0] T_MAX = 32'sd32767;
  localparam logic signed [31:0] T_MIN = -32'sd32768;
  localparam logic signed [31:0] P_MAX = 32'sd262143;

  typedef enum logic [2:0] {
    REG_AC1_AC2 = 3'd0,
    REG_AC3_AC4 = 3'd1,
    REG_AC5_AC6 = 3'd2,
    REG_B1_B2   = 3'd3,
    REG_MC_MD   = 3'd4,
    REG_OSS     = 3'd5
  } reg_idx_t;

  // low 32 bits of the product
  function automatic logic [31:0] mul_lo(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] lo;
    lo = a * b;
    return lo;
  endfunction

  function automatic logic [31:0] asr32(input logic [31:0] v, input logic [4:0] n);
    logic signed [31:0] s;
    s = v;
    return s >>> n;
  endfunction

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

endpackage

[src/btpc_div_pipe.sv]
// ----------------------------------------------------------------------------
// btpc_div_pipe
// Pipelined restoring unsigned divider, STEP quotient bits per stage
// ----------------------------------------------------------------------------
module btpc_div_pipe import btpc_pkg::*; #(
  parameter int DW   = 32,
  parameter int PW   = 8,
  parameter int STEP = BTPC_DIV_STEP
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [DW-1:0] dividend,
  input  logic [31:0]   divisor,
  input  logic [PW-1:0] side_in,
  output logic          out_valid,
  output logic [DW-1:0] quotient,
  output logic [PW-1:0] side_out
);

  localparam int NS = (DW + STEP - 1) / STEP;
  localparam int W  = NS * STEP;

  logic [NS:0]   vld;
  logic [32:0]   rem  [NS+1];
  logic [W-1:0]  work [NS+1];
  logic [31:0]   dvs  [NS+1];
  logic [PW-1:0] side [NS+1];

  assign vld[0]  = in_valid;
  assign rem[0]  = '0;
  assign work[0] = W'(dividend);
  assign dvs[0]  = divisor;
  assign side[0] = side_in;

  for (genvar g = 0; g < NS; g++) begin : g_stage
    logic [32:0]  r_n;
    logic [W-1:0] w_n;

    always_comb begin
      logic ge;
      r_n = rem[g];
      w_n = work[g];
      for (int i = 0; i < STEP; i++) begin
        r_n = {r_n[31:0], w_n[W-1]};
        ge  = (r_n >= {1'b0, dvs[g]});
        if (ge) begin
          r_n = r_n - {1'b0, dvs[g]};
        end
        w_n = {w_n[W-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g+1] <= 1'b0;
      end else begin
        vld[g+1] <= vld[g];
      end
      rem[g+1]  <= r_n;
      work[g+1] <= w_n;
      dvs[g+1]  <= dvs[g];
      side[g+1] <= side[g];
    end
  end

  assign out_valid = vld[NS];
  assign quotient  = work[NS][DW-1:0];
  assign side_out  = side[NS];

endmodule

[src/baro_temp_pressure_compensation.sv]
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation
// Integer temperature and pressure compensation of a barometric sensor
// ----------------------------------------------------------------------------
// A raw sample pair (raw_temperature, raw_pressure) is taken at a clock edge
// where start is high and busy is low. busy never rises: a new pair can be
// taken in every cycle. Each pair gives one result on temperature_tenths,
// pressure_pa and divide_error, shown for one cycle with done high.
// The two pipelined dividers (temperature and pressure) and the multiply
// stages between them form the path from the accepting edge to the edge
// that takes the result. Throughput is one pair per cycle.
// Calibration registers are written through wr_en, wr_index and wr_data and
// must stay unchanged while samples are in flight.
// A zero divisor gives divide_error high with zero temperature and pressure.
// Reset clears all in-flight samples and loads the default calibration.
// The receiver cannot stall; every result appears once, for one cycle.
// ----------------------------------------------------------------------------
`include "baro_temp_pressure_compensation_assert.svh"

module baro_temp_pressure_compensation import btpc_pkg::*; #(
  parameter int DIV_STEP = BTPC_DIV_STEP
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [15:0]        raw_temperature,
  input  logic [18:0]        raw_pressure,
  output logic               done,
  output logic signed [15:0] temperature_tenths,
  output logic [17:0]        pressure_pa,
  output logic               divide_error,
  input  logic               wr_en,
  input  logic [2:0]         wr_index,
  input  logic [31:0]        wr_data
);

  localparam int NS1 = (27 + DIV_STEP - 1) / DIV_STEP;
  localparam int NS2 = (32 + DIV_STEP - 1) / DIV_STEP;
  localparam int LAT = 14 + NS1 + NS2;
  localparam int PW1 = 53;
  localparam int PW2 = 18;

  // calibration registers
  logic [31:0] cal_ac1_ac2, cal_ac3_ac4, cal_ac5_ac6, cal_b1_b2, cal_mc_md;
  logic [1:0]  oss;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_ac1_ac2 <= RST_AC1_AC2;
      cal_ac3_ac4 <= RST_AC3_AC4;
      cal_ac5_ac6 <= RST_AC5_AC6;
      cal_b1_b2   <= RST_B1_B2;
      cal_mc_md   <= RST_MC_MD;
      oss         <= RST_OSS;
    end else if (wr_en) begin
      case (wr_index)
        REG_AC1_AC2: cal_ac1_ac2 <= wr_data;
        REG_AC3_AC4: cal_ac3_ac4 <= wr_data;
        REG_AC5_AC6: cal_ac5_ac6 <= wr_data;
        REG_B1_B2:   cal_b1_b2   <= wr_data;
        REG_MC_MD:   cal_mc_md   <= wr_data;
        REG_OSS:     oss         <= wr_data[1:0];
        default: begin
        end
      endcase
    end
  end

  logic [15:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
  assign ac1 = cal_ac1_ac2[31:16];
  assign ac2 = cal_ac1_ac2[15:0];
  assign ac3 = cal_ac3_ac4[31:16];
  assign ac4 = cal_ac3_ac4[15:0];
  assign ac5 = cal_ac5_ac6[31:16];
  assign ac6 = cal_ac5_ac6[15:0];
  assign b1  = cal_b1_b2[31:16];
  assign b2  = cal_b1_b2[15:0];
  assign mc  = cal_mc_md[31:16];
  assign md  = cal_mc_md[15:0];

  assign busy = 1'b0;

  logic [14:1] v;

  // stage 1: (ut - ac6) * ac5
  logic [31:0] s1_pt;
  logic [18:0] s1_up;
  logic signed [16:0] s1_dt;
  logic signed [33:0] s1_prod;
  assign s1_dt   = $signed({1'b0, raw_temperature}) - $signed({1'b0, ac6});
  assign s1_prod = s1_dt * $signed({1'b0, ac5});

  always_ff @(posedge clk) begin
    s1_pt <= s1_prod[31:0];
    s1_up <= raw_pressure;
  end

  // stage 2: x1 and temperature divisor
  logic [31:0] s2_x1, s2_d1, s2_x1_n;
  logic [18:0] s2_up;
  logic        s2_err;
  assign s2_x1_n = asr32(s1_pt, 5'd15);

  always_ff @(posedge clk) begin
    s2_x1  <= s2_x1_n;
    s2_d1  <= s2_x1_n + sx16(md);
    s2_err <= ((s2_x1_n + sx16(md)) == 32'd0);
    s2_up  <= s1_up;
  end

  // stage 3: magnitudes for the temperature divider
  logic [26:0] s3_num;
  logic [31:0] s3_den;
  logic [PW1-1:0] s3_side;
  logic [16:0] mc_abs;
  assign mc_abs = mc[15] ? (17'd0 - {1'b0, mc}) : {1'b0, mc};

  always_ff @(posedge clk) begin
    s3_num  <= {mc_abs[15:0], 11'd0};
    s3_den  <= s2_d1[31] ? (32'd0 - s2_d1) : s2_d1;
    s3_side <= {s2_x1, s2_up, s2_err, mc[15] ^ s2_d1[31]};
  end

  logic           d1_valid;
  logic [26:0]    d1_q;
  logic [PW1-1:0] d1_side;

  btpc_div_pipe #(.DW(27), .PW(PW1), .STEP(DIV_STEP)) u_div_t (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v[3]),
    .dividend  (s3_num),
    .divisor   (s3_den),
    .side_in   (s3_side),
    .out_valid (d1_valid),
    .quotient  (d1_q),
    .side_out  (d1_side)
  );

  // stage 4: b5
  logic [31:0] s4_b5, q1x, x2t;
  logic [18:0] s4_up;
  logic        s4_err;
  assign q1x = {5'd0, d1_q};
  assign x2t = d1_side[0] ? (32'd0 - q1x) : q1x;

  always_ff @(posedge clk) begin
    s4_b5  <= d1_side[52:21] + x2t;
    s4_up  <= d1_side[20:2];
    s4_err <= d1_side[1];
  end

  // stage 5: temperature result and b6
  logic [31:0] s5_b6;
  logic [15:0] s5_t;
  logic [18:0] s5_up;
  logic        s5_err;
  logic signed [31:0] t_w;
  logic [15:0] t_sat;
  assign t_w = asr32(s4_b5 + 32'd8, 5'd4);

  always_comb begin
    if (t_w > T_MAX) begin
      t_sat = T_MAX[15:0];
    end else if (t_w < T_MIN) begin
      t_sat = T_MIN[15:0];
    end else begin
      t_sat = t_w[15:0];
    end
  end

  always_ff @(posedge clk) begin
    s5_b6  <= s4_b5 - C_B6_OFFSET;
    s5_t   <= t_sat;
    s5_up  <= s4_up;
    s5_err <= s4_err;
  end

  // stage 6: first products of b6
  logic [31:0] s6_sq, s6_mac2, s6_mac3;
  logic [15:0] s6_t;
  logic [18:0] s6_up;
  logic        s6_err;

  always_ff @(posedge clk) begin
    s6_sq   <= mul_lo(s5_b6, s5_b6);
    s6_mac2 <= mul_lo(sx16(ac2), s5_b6);
    s6_mac3 <= mul_lo(sx16(ac3), s5_b6);
    s6_t    <= s5_t;
    s6_up   <= s5_up;
    s6_err  <= s5_err;
  end

  // stage 7: second order products
  logic [31:0] s7_mb2, s7_mb1, s7_x2a, s7_x1b, sq;
  logic [15:0] s7_t;
  logic [18:0] s7_up;
  logic        s7_err;
  assign sq = asr32(s6_sq, 5'd12);

  always_ff @(posedge clk) begin
    s7_mb2 <= mul_lo(sx16(b2), sq);
    s7_mb1 <= mul_lo(sx16(b1), sq);
    s7_x2a <= asr32(s6_mac2, 5'd11);
    s7_x1b <= asr32(s6_mac3, 5'd13);
    s7_t   <= s6_t;
    s7_up  <= s6_up;
    s7_err <= s6_err;
  end

  // stage 8: b3 and x3
  logic [31:0] s8_b3, s8_x3, x3a, b3s;
  logic [15:0] s8_t;
  logic [18:0] s8_up;
  logic        s8_err;
  assign x3a = asr32(s7_mb2, 5'd11) + s7_x2a;
  assign b3s = ((sx16(ac1) << 2) + x3a) << oss;

  always_ff @(posedge clk) begin
    s8_b3  <= asr32(b3s + 32'd2, 5'd2);
    s8_x3  <= asr32(s7_x1b + asr32(s7_mb1, 5'd16) + 32'd2, 5'd2);
    s8_t   <= s7_t;
    s8_up  <= s7_up;
    s8_err <= s7_err;
  end

  // stage 9: b4 product and up - b3
  logic [31:0] s9_b4p, s9_diff;
  logic [15:0] s9_t;
  logic        s9_err;

  always_ff @(posedge clk) begin
    s9_b4p  <= mul_lo({16'd0, ac4}, s8_x3 + C_B4_BIAS);
    s9_diff <= {13'd0, s8_up} - s8_b3;
    s9_t    <= s8_t;
    s9_err  <= s8_err;
  end

  // stage 10: b4 and b7
  logic [31:0] s10_b4, s10_b7;
  logic [15:0] s10_t;
  logic        s10_err;

  always_ff @(posedge clk) begin
    s10_b4  <= {15'd0, s9_b4p[31:15]};
    s10_b7  <= mul_lo(s9_diff, C_B7_SCALE >> oss);
    s10_t   <= s9_t;
    s10_err <= s9_err;
  end

  // stage 11: pressure divider operands
  logic [31:0]    s11_num, s11_den;
  logic [PW2-1:0] s11_side;
  logic           b7_hi;
  assign b7_hi = ((s10_b7 & C_SIGN_BIT) != 32'd0);

  always_ff @(posedge clk) begin
    s11_num  <= b7_hi ? s10_b7 : {s10_b7[30:0], 1'b0};
    s11_den  <= s10_b4;
    s11_side <= {s10_t, s10_err | (s10_b4 == 32'd0), b7_hi};
  end

  logic           d2_valid;
  logic [31:0]    d2_q;
  logic [PW2-1:0] d2_side;

  btpc_div_pipe #(.DW(32), .PW(PW2), .STEP(DIV_STEP)) u_div_p (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v[11]),
    .dividend  (s11_num),
    .divisor   (s11_den),
    .side_in   (s11_side),
    .out_valid (d2_valid),
    .quotient  (d2_q),
    .side_out  (d2_side)
  );

  // stage 12: pressure correction products
  logic [31:0] s12_p, s12_sqp, s12_m7, p_raw, p_sh;
  logic [15:0] s12_t;
  logic        s12_err;
  assign p_raw = d2_side[0] ? {d2_q[30:0], 1'b0} : d2_q;
  assign p_sh  = asr32(p_raw, 5'd8);

  always_ff @(posedge clk) begin
    s12_p   <= p_raw;
    s12_sqp <= mul_lo(p_sh, p_sh);
    s12_m7  <= mul_lo(C_P_K2, p_raw);
    s12_t   <= d2_side[17:2];
    s12_err <= d2_side[1];
  end

  // stage 13
  logic [31:0] s13_p, s13_m3, s13_x2;
  logic [15:0] s13_t;
  logic        s13_err;

  always_ff @(posedge clk) begin
    s13_p   <= s12_p;
    s13_m3  <= mul_lo(s12_sqp, C_P_K1);
    s13_x2  <= asr32(s12_m7, 5'd16);
    s13_t   <= s12_t;
    s13_err <= s12_err;
  end

  // stage 14: final pressure, saturation, error zeroing
  logic signed [31:0] p_fin;
  logic [17:0]        p_sat;
  assign p_fin = s13_p + asr32(asr32(s13_m3, 5'd16) + s13_x2 + C_P_K3, 5'd4);

  always_comb begin
    if (p_fin < 32'sd0) begin
      p_sat = '0;
    end else if (p_fin > P_MAX) begin
      p_sat = P_MAX[17:0];
    end else begin
      p_sat = p_fin[17:0];
    end
  end

  always_ff @(posedge clk) begin
    temperature_tenths <= s13_err ? 16'sd0 : $signed(s13_t);
    pressure_pa        <= s13_err ? 18'd0 : p_sat;
    divide_error       <= s13_err;
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v[1]  <= start & ~busy;
      v[2]  <= v[1];
      v[3]  <= v[2];
      v[4]  <= d1_valid;
      v[5]  <= v[4];
      v[6]  <= v[5];
      v[7]  <= v[6];
      v[8]  <= v[7];
      v[9]  <= v[8];
      v[10] <= v[9];
      v[11] <= v[10];
      v[12] <= d2_valid;
      v[13] <= v[12];
      v[14] <= v[13];
    end
  end

  assign done = v[14];

  `ASSERT_PROP(a_latency, clk, rst, (start && !busy) |-> ##LAT done)
  `ASSERT_PROP(a_no_spurious, clk, rst, done |-> $past(start, LAT))
  `ASSERT_PROP(a_err_zero, clk, rst, (done && divide_error) |-> (temperature_tenths == 16'sd0 && pressure_pa == 18'd0))

endmodule

[tb/sv/tb_baro_temp_pressure_compensation.sv]
// ----------------------------------------------------------------------------
// tb_baro_temp_pressure_compensation
// Self-checking bench for the barometric temperature and pressure compensation
// ----------------------------------------------------------------------------
// Raw sample pairs go in with random gaps. A scoreboard predicts each
// compensated result from its own copy of the calibration and compares the
// results, in order, as they come out. Calibration is rewritten between
// phases once the pipeline has drained: defaults, zero divisors, all-ones,
// every oversampling setting, ignored register indexes, then random sets.
// ----------------------------------------------------------------------------
module tb_baro_temp_pressure_compensation;
  import btpc_pkg::*;

  localparam int CYC_LIMIT = 400000;
  localparam int DRAIN = 60;
  localparam logic [2:0] REG_SPARE6 = 3'd6;
  localparam logic [2:0] REG_SPARE7 = 3'd7;

  typedef struct {
    logic signed [15:0] temp;
    logic [17:0]        pres;
    logic               derr;
  } comp_result_t;

  class comp_scoreboard;
    logic [31:0]  cal [5];
    logic [1:0]   oss;
    comp_result_t pending_q [$];
    int           errors;

    function new();
      cal[0] = RST_AC1_AC2; cal[1] = RST_AC3_AC4; cal[2] = RST_AC5_AC6;
      cal[3] = RST_B1_B2;   cal[4] = RST_MC_MD;   oss = RST_OSS;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] val);
      case (idx)
        REG_AC1_AC2: cal[0] = val;
        REG_AC3_AC4: cal[1] = val;
        REG_AC5_AC6: cal[2] = val;
        REG_B1_B2:   cal[3] = val;
        REG_MC_MD:   cal[4] = val;
        REG_OSS:     oss = val[1:0];
        default: ;
      endcase
    endfunction

    // predict the compensated pair for one accepted sample
    function void note_sample(logic [15:0] ut_raw, logic [18:0] up_raw);
      int ut, ac1, ac2, ac3, ac5, ac6, b1, b2, mc, md;
      int x1, x2, x3, b5, b6, b3, sq, p, t;
      int unsigned up, ac4, b4, b7;
      comp_result_t r;
      ut = ut_raw; up = up_raw;
      ac1 = $signed(cal[0][31:16]); ac2 = $signed(cal[0][15:0]);
      ac3 = $signed(cal[1][31:16]); ac4 = cal[1][15:0];
      ac5 = cal[2][31:16];          ac6 = cal[2][15:0];
      b1 = $signed(cal[3][31:16]);  b2 = $signed(cal[3][15:0]);
      mc = $signed(cal[4][31:16]);  md = $signed(cal[4][15:0]);
      r.temp = 0; r.pres = 0; r.derr = 1;
      x1 = ((ut - ac6) * ac5) >>> 15;
      x2 = x1 + md;
      if (x2 != 0) begin
        x2 = (mc * 2048) / x2;
        b5 = x1 + x2;
        t = (b5 + 8) >>> 4;
        b6 = b5 - 4000;
        sq = (b6 * b6) >>> 12;
        x1 = (b2 * sq) >>> 11;
        x2 = (ac2 * b6) >>> 11;
        x3 = x1 + x2;
        b3 = int'(32'(ac1 * 4 + x3) << oss);
        b3 = (b3 + 2) >>> 2;
        x1 = (ac3 * b6) >>> 13;
        x2 = (b1 * sq) >>> 16;
        x3 = (x1 + x2 + 2) >>> 2;
        b4 = (ac4 * (32'(x3) + 32'd32768)) >> 15;
        if (b4 != 0) begin
          b7 = (up - 32'(b3)) * (32'd50000 >> oss);
          if (b7 < 32'h8000_0000) p = (b7 << 1) / b4;
          else p = (b7 / b4) << 1;
          x1 = (p >>> 8) * (p >>> 8);
          x1 = (x1 * 3038) >>> 16;
          x2 = (-7357 * p) >>> 16;
          p = p + ((x1 + x2 + 3791) >>> 4);
          if (t > 32767) t = 32767;
          if (t < -32768) t = -32768;
          if (p < 0) p = 0;
          if (p > 262143) p = 262143;
          r.temp = t[15:0]; r.pres = p[17:0]; r.derr = 0;
        end
      end
      pending_q.push_back(r);
    endfunction

    function void check_result(logic signed [15:0] t, logic [17:0] p, logic e);
      comp_result_t x;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result t=%0d p=%0d err=%0b", $time, t, p, e);
        errors++;
        return;
      end
      x = pending_q.pop_front();
      if (t !== x.temp) begin
        $display("%0t: temperature_tenths expected %0d actual %0d", $time, x.temp, t);
        errors++;
      end
      if (p !== x.pres) begin
        $display("%0t: pressure_pa expected %0d actual %0d", $time, x.pres, p);
        errors++;
      end
      if (e !== x.derr) begin
        $display("%0t: divide_error expected %0b actual %0b", $time, x.derr, e);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst, start, busy, done, divide_error, wr_en;
  logic [15:0] raw_temperature;
  logic [18:0] raw_pressure;
  logic signed [15:0] temperature_tenths;
  logic [17:0] pressure_pa;
  logic [2:0] wr_index;
  logic [31:0] wr_data;
  comp_scoreboard sb;
  int cycles;

  baro_temp_pressure_compensation dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .raw_temperature(raw_temperature), .raw_pressure(raw_pressure),
    .done(done), .temperature_tenths(temperature_tenths),
    .pressure_pa(pressure_pa), .divide_error(divide_error),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && done) sb.check_result(temperature_tenths, pressure_pa, divide_error);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYC_LIMIT) begin
      $display("baro_temp_pressure_compensation test failed");
      $finish;
    end
  end

  task automatic write_cal(logic [2:0] idx, logic [31:0] val);
    wr_en <= 1'b1; wr_index <= idx; wr_data <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    wr_en <= 1'b0;
  endtask

  task automatic drain();
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic send_sample(logic [15:0] ut, logic [18:0] up, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1; raw_temperature <= ut; raw_pressure <= up;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_sample(ut, up);
  endtask

  function automatic int pick_gap(bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic random_samples(int n);
    bit burst;
    logic [15:0] ut;
    logic [18:0] up;
    for (int i = 0; i < n; i++) begin
      if (i % 20 == 0) burst = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 2) == 0) begin
        ut = 16'($urandom); up = 19'($urandom);
      end else begin
        ut = 16'($urandom_range(20000, 36000));
        up = 19'($urandom_range(15000, 30000) << sb.oss);
      end
      send_sample(ut, up, pick_gap(burst));
    end
    start <= 1'b0;
  endtask

  task automatic load_cal(logic [31:0] a, logic [31:0] b, logic [31:0] c,
                          logic [31:0] d, logic [31:0] e, logic [1:0] o);
    write_cal(REG_AC1_AC2, a); write_cal(REG_AC3_AC4, b);
    write_cal(REG_AC5_AC6, c); write_cal(REG_B1_B2, d);
    write_cal(REG_MC_MD, e);   write_cal(REG_OSS, {30'b0, o});
  endtask

  initial begin
    sb = new();
    cycles = 0;
    rst = 1'b1; start = 1'b0; wr_en = 1'b0; wr_index = '0; wr_data = '0;
    raw_temperature = '0; raw_pressure = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // defaults: field extremes and a typical sample
    send_sample(16'd0, 19'd0, 0);
    send_sample(16'hFFFF, 19'h7FFFF, 0);
    send_sample(16'd0, 19'h7FFFF, 1);
    send_sample(16'hFFFF, 19'd0, 0);
    send_sample(16'd27898, 19'd95372, 0);
    send_sample(16'h5555, 19'h2AAAA, 2);
    send_sample(16'hAAAA, 19'h55555, 0);
    start <= 1'b0;
    drain();

    // zero temperature divisor: ac5 and md zero
    load_cal(RST_AC1_AC2, RST_AC3_AC4, 32'h0000_1234, RST_B1_B2, 32'hD4BD_0000, 2'd0);
    send_sample(16'd27898, 19'd23843, 0);
    send_sample(16'hFFFF, 19'h7FFFF, 0);
    start <= 1'b0;
    drain();
    // zero pressure divisor: ac4 zero
    load_cal(RST_AC1_AC2, 32'hC7A5_0000, RST_AC5_AC6, RST_B1_B2, RST_MC_MD, 2'd1);
    send_sample(16'd27898, 19'd47686, 0);
    send_sample(16'd100, 19'd5, 0);
    start <= 1'b0;
    drain();
    // all ones, then all zeros, highest oversampling
    load_cal('1, '1, '1, '1, '1, 2'd3);
    send_sample(16'd0, 19'd0, 0);
    send_sample(16'hFFFF, 19'h7FFFF, 0);
    send_sample(16'd27898, 19'd190744, 0);
    start <= 1'b0;
    drain();
    load_cal('0, '0, '0, '0, '0, 2'd3);
    send_sample(16'd1234, 19'd4321, 0);
    start <= 1'b0;
    drain();
    // writes to unused indexes are ignored
    load_cal(RST_AC1_AC2, RST_AC3_AC4, RST_AC5_AC6, RST_B1_B2, RST_MC_MD, RST_OSS);
    write_cal(REG_SPARE6, '1);
    write_cal(REG_SPARE7, 32'h1234_5678);
    send_sample(16'd27898, 19'd95372, 0);
    send_sample(16'd30000, 19'd100000, 0);
    start <= 1'b0;
    drain();

    for (int ph = 0; ph < 12; ph++) begin
      if (ph % 2 == 0)
        load_cal(RST_AC1_AC2 ^ ($urandom & 32'h00FF_00FF),
                 RST_AC3_AC4 ^ ($urandom & 32'h00FF_00FF),
                 RST_AC5_AC6 ^ ($urandom & 32'h00FF_00FF),
                 RST_B1_B2 ^ ($urandom & 32'h000F_000F),
                 RST_MC_MD ^ ($urandom & 32'h00FF_00FF), ph[2:1]);
      else
        load_cal($urandom, $urandom, $urandom, $urandom, $urandom,
                 2'($urandom_range(0, 3)));
      random_samples(95);
      drain();
    end

    if (sb.errors == 0)
      $display("baro_temp_pressure_compensation test passed");
    else
      $display("baro_temp_pressure_compensation test failed");
    $finish;
  end
endmodule
